// File: rtl/tcce_pkg.sv
// Package for the text console cursor engine: constants, register codes
// and the result record type. No dependencies.
`timescale 1ns / 1ps

package tcce_pkg;

  // Character codes
  localparam logic [7:0] CHAR_TAB = 8'd9;
  localparam logic [7:0] CHAR_LF  = 8'd10;
  localparam logic [7:0] CHAR_CR  = 8'd13;

  // Register reset values and limits
  localparam logic [15:0] ATTR_RESET = 16'h1700;
  localparam logic [7:0]  COLS_RESET = 8'd80;
  localparam logic [5:0]  ROWS_RESET = 6'd25;
  localparam logic [7:0]  MAX_COLS   = 8'd128;
  localparam logic [5:0]  MAX_ROWS   = 6'd32;

  // Cell indices wrap at this count (power of two, 12-bit index)
  localparam int unsigned MAX_CELLS = 4096;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_ATTRIBUTE = 2'd0,
    REG_COLUMNS   = 2'd1,
    REG_ROWS      = 2'd2
  } cfg_reg_t;

  // One result item
  typedef struct packed {
    logic        cell_write;
    logic [11:0] cell_address;
    logic [15:0] cell_value;
    logic        scroll_up;
    logic [11:0] cursor_position;
    logic [7:0]  serial_byte;
    logic        last_result;
  } result_t;

endpackage

// File: rtl/tcce_if.sv
// Valid/ready channel interfaces for the text console cursor engine.
// Character input channel and result channel; no dependencies.
`timescale 1ns / 1ps

interface tcce_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;

  modport source (output valid, output char_byte, input ready);
  modport sink   (input valid, input char_byte, output ready);
endinterface

interface tcce_result_if;
  logic        valid;
  logic        ready;
  logic        cell_write;
  logic [11:0] cell_address;
  logic [15:0] cell_value;
  logic        scroll_up;
  logic [11:0] cursor_position;
  logic [7:0]  serial_byte;
  logic        last_result;

  modport source (output valid, output cell_write, output cell_address, output cell_value,
                  output scroll_up, output cursor_position, output serial_byte,
                  output last_result, input ready);
  modport sink   (input valid, input cell_write, input cell_address, input cell_value,
                  input scroll_up, input cursor_position, input serial_byte,
                  input last_result, output ready);
endinterface

// File: rtl/text_console_cursor_engine_unit.sv
// Top level of the text console cursor engine: cursor update, cell write
// and scroll generation. Depends on tcce_pkg and the interfaces in tcce_if.
`timescale 1ns / 1ps
//
// Channel  Dir  Handshake        Payload
// -------  ---  ---------------  ------------------------------------------
// in_ch    in   valid/ready      char_byte[7:0]
// out_ch   out  valid/ready      cell_write, cell_address[11:0],
//                                cell_value[15:0], scroll_up,
//                                cursor_position[11:0], serial_byte[7:0],
//                                last_result
// cfg      in   cfg_we only      cfg_index[1:0], cfg_data[15:0]
//
// An item's result is registered into the output register at accept.
// Ordinary bytes and tabs give one result each; a newline gives two, since
// its line-feed result follows the carriage-return result out of the same
// output register. The cursor state updates at accept, so items stream back
// to back. Synchronous active-low reset clears cursor and valid flags and
// presets the configuration registers. in_ch.ready drops while the output
// register is full and not being taken, or while a line-feed result pends.

module text_console_cursor_engine_unit
  import tcce_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  tcce_char_if.sink     in_ch,
  tcce_result_if.source out_ch,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [15:0]   cfg_data
);

  // Configuration registers
  logic [15:0] attr_r;
  logic [7:0]  cols_r;
  logic [5:0]  rows_r;

  // Cursor state
  logic [7:0]  col_r;
  logic [5:0]  row_r;

  // Output stage
  result_t     out_r;
  logic        out_valid_r;
  logic        pend_r;      // line-feed result still to follow

  logic        in_accept;
  logic        out_take;

  // Datapath for the accepted item
  logic [7:0]  w_eff;
  logic [5:0]  h_eff;
  logic [8:0]  col_a;
  logic [6:0]  row_a;
  logic [8:0]  col_p8;
  logic        is_lf;
  logic        is_tab;
  logic        do_wr;
  logic        do_scr;
  logic [7:0]  col_nxt;
  logic [5:0]  row_nxt;
  logic [14:0] addr_sum;
  logic [14:0] cur_sum;
  result_t     res_nxt;

  assign out_take  = out_valid_r & out_ch.ready;
  assign in_ch.ready = (~out_valid_r | out_ch.ready) & ~pend_r;
  assign in_accept = in_ch.valid & in_ch.ready;

  // Clamp screen size to its legal range
  always_comb begin
    if (cols_r == 8'd0) begin
      w_eff = 8'd1;
    end else if (cols_r > MAX_COLS) begin
      w_eff = MAX_COLS;
    end else begin
      w_eff = cols_r;
    end
    if (rows_r == 6'd0) begin
      h_eff = 6'd1;
    end else if (rows_r > MAX_ROWS) begin
      h_eff = MAX_ROWS;
    end else begin
      h_eff = rows_r;
    end
  end

  // Cursor movement: character step, then row wrap, then bottom scroll
  always_comb begin
    is_lf  = (in_ch.char_byte == CHAR_LF);
    is_tab = (in_ch.char_byte == CHAR_TAB);
    do_wr  = 1'b0;
    do_scr = 1'b0;
    col_a  = {1'b0, col_r};
    row_a  = {1'b0, row_r};
    col_p8 = {1'b0, col_r} + 9'd8;   // col+1 rounded up to a tab stop
    priority if (is_lf) begin
      col_a = 9'd0;
      row_a = {1'b0, row_r} + 7'd1;
    end else if (is_tab) begin
      col_a = {col_p8[8:3], 3'b000};
    end else begin
      do_wr = 1'b1;
      col_a = {1'b0, col_r} + 9'd1;
    end
    if (col_a >= {1'b0, w_eff}) begin
      col_a = 9'd0;
      row_a = row_a + 7'd1;
    end
    if (row_a >= {1'b0, h_eff}) begin
      do_scr = 1'b1;
      col_a  = 9'd0;
      row_a  = {1'b0, h_eff - 6'd1};
    end
    col_nxt = col_a[7:0];
    row_nxt = row_a[5:0];
  end

  // Cell indices: row*width+column, taken modulo the cell count
  assign addr_sum = 15'(row_r) * 15'(w_eff) + 15'(col_r);
  assign cur_sum  = 15'(row_nxt) * 15'(w_eff) + 15'(col_nxt);

  always_comb begin
    res_nxt.cell_write      = do_wr;
    res_nxt.cell_address    = do_wr ? 12'(addr_sum % MAX_CELLS) : 12'd0;
    res_nxt.cell_value      = do_wr ? (attr_r | {8'd0, in_ch.char_byte}) : 16'd0;
    res_nxt.scroll_up       = do_scr;
    res_nxt.cursor_position = 12'(cur_sum % MAX_CELLS);
    res_nxt.serial_byte     = is_lf ? CHAR_CR : in_ch.char_byte;
    res_nxt.last_result     = ~is_lf;
  end

  // Configuration writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= ATTR_RESET;
      cols_r <= COLS_RESET;
      rows_r <= ROWS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ATTRIBUTE: attr_r <= cfg_data;
        REG_COLUMNS:   cols_r <= cfg_data[7:0];
        REG_ROWS:      rows_r <= cfg_data[5:0];
        default:       ;
      endcase
    end
  end

  // Cursor and output control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= 8'd0;
      row_r       <= 6'd0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else if (in_accept) begin
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      out_valid_r <= 1'b1;
      pend_r      <= is_lf;
    end else if (out_take) begin
      if (pend_r) begin
        pend_r <= 1'b0;
      end else begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output payload; after the carriage return goes, the line feed follows
  // with the same cursor
  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_r <= res_nxt;
    end else if (out_take && pend_r) begin
      out_r.serial_byte <= CHAR_LF;
      out_r.scroll_up   <= 1'b0;
      out_r.last_result <= 1'b1;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.cell_write      = out_r.cell_write;
  assign out_ch.cell_address    = out_r.cell_address;
  assign out_ch.cell_value      = out_r.cell_value;
  assign out_ch.scroll_up       = out_r.scroll_up;
  assign out_ch.cursor_position = out_r.cursor_position;
  assign out_ch.serial_byte     = out_r.serial_byte;
  assign out_ch.last_result     = out_r.last_result;

endmodule
